FILE: design/ldrt_pkg.sv
package ldrt_pkg;

    // Alphabet and string length limits
    localparam int unsigned ALPHABET_SIZE  = 256;
    localparam int unsigned POSITION_LIMIT = 65536;

    // Field widths
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned OUT_W  = 17;
    localparam int unsigned SLOT_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int unsigned POS_W  = $clog2(POSITION_LIMIT + 1);
    localparam int unsigned NUM_CODES = 1 << CHAR_W;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [POS_W-1:0]  t_pos;
    typedef t_slot             t_slot_tab [NUM_CODES];

    // Byte code to table slot, reduced modulo the alphabet size
    function automatic t_slot_tab build_slot_tab();
        t_slot_tab tab;
        for (int i = 0; i < NUM_CODES; i++) begin
            tab[i] = SLOT_W'(i % ALPHABET_SIZE);
        end
        return tab;
    endfunction

    localparam t_slot_tab SLOT_TAB = build_slot_tab();

    // Write command from the update stage to the position table
    typedef struct packed {
        logic  wr_en;
        logic  clear;
        t_slot slot;
        t_pos  pos;
    } t_tbl_wr;

endpackage

FILE: design/ldrt_table.sv
module ldrt_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  ldrt_pkg::t_slot       i_rd_slot,
    output ldrt_pkg::t_pos        o_rd_data,
    input  ldrt_pkg::t_slot       i_vld_slot,
    output logic                  o_vld,
    input  ldrt_pkg::t_tbl_wr     i_wr
);

    // Last position + 1 of each byte value; no reset, qualified by valid bits
    ldrt_pkg::t_pos r_mem [ldrt_pkg::ALPHABET_SIZE];
    ldrt_pkg::t_pos r_rd_data;
    logic [ldrt_pkg::ALPHABET_SIZE-1:0] r_vld;

    // Synchronous write port
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.slot] <= i_wr.pos;
        end
    end

    // Synchronous read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
        end
    end

    // Valid bits: cleared at once at reset and at end of string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            r_vld <= '0;
        end else if (i_wr.wr_en) begin
            r_vld[i_wr.slot] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_vld     = r_vld[i_vld_slot];

endmodule

FILE: design/longest_distinct_run_tracker.sv
// Longest repeat-free run tracker. Bytes of a string enter one per transaction, the last one
// flagged; every byte yields one result carrying the current window length and the best
// length so far, with string_done on the final byte, after which all state clears for the
// next string. The block sustains one byte per cycle while the output is not stalled: the
// per-byte position table is read synchronously, then the window update and table write-back
// feed the output register; a write in the cycle of a read to the same byte is forwarded.
// Bytes past the length limit are dropped, flagged by too_long, with zero window.
module longest_distinct_run_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ldrt_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                         i_last_of_string,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ldrt_pkg::OUT_W-1:0]   o_best_length,
    output logic [ldrt_pkg::OUT_W-1:0]   o_window_length,
    output logic                         o_string_done,
    output logic                         o_too_long
);

    // Update stage registers
    logic                  r_s1_vld;
    ldrt_pkg::t_slot       r_s1_slot;
    logic                  r_s1_last;
    logic                  r_s1_fwd_hit;
    ldrt_pkg::t_pos        r_s1_fwd_pos;

    // Per-string state
    ldrt_pkg::t_pos        r_pos;
    ldrt_pkg::t_pos        r_win_begin;
    ldrt_pkg::t_pos        r_best;
    logic                  r_ovf;

    // Output register
    logic                        r_out_vld;
    logic [ldrt_pkg::OUT_W-1:0]  r_out_best;
    logic [ldrt_pkg::OUT_W-1:0]  r_out_win;
    logic                        r_out_done;
    logic                        r_out_long;

    logic                  s1_adv;
    logic                  in_acc;
    ldrt_pkg::t_slot       in_slot;
    ldrt_pkg::t_pos        rd_data;
    logic                  tbl_vld;
    ldrt_pkg::t_tbl_wr     tbl_wr;
    logic                  at_limit;
    ldrt_pkg::t_pos        prev;
    ldrt_pkg::t_pos        n_win_begin;
    ldrt_pkg::t_pos        n_pos;
    ldrt_pkg::t_pos        win;
    ldrt_pkg::t_pos        n_best;

    // Handshake
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_slot    = ldrt_pkg::SLOT_TAB[i_char_code];

    ldrt_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_slot  (in_slot),
        .o_rd_data  (rd_data),
        .i_vld_slot (r_s1_slot),
        .o_vld      (tbl_vld),
        .i_wr       (tbl_wr)
    );

    // Window update
    always_comb begin
        at_limit = (r_pos >= ldrt_pkg::POS_W'(ldrt_pkg::POSITION_LIMIT));
        if (!tbl_vld) begin
            prev = '0;
        end else if (r_s1_fwd_hit) begin
            prev = r_s1_fwd_pos;
        end else begin
            prev = rd_data;
        end
        n_win_begin = (prev > r_win_begin) ? prev : r_win_begin;
        n_pos       = r_pos + ldrt_pkg::POS_W'(1);
        win         = n_pos - n_win_begin;
        n_best      = (win > r_best) ? win : r_best;
    end

    // Table write-back
    always_comb begin
        tbl_wr.wr_en = s1_adv && !at_limit;
        tbl_wr.clear = s1_adv && r_s1_last;
        tbl_wr.slot  = r_s1_slot;
        tbl_wr.pos   = n_pos;
    end

    // Read stage: capture request and forwarding from a same-cycle write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_slot    <= in_slot;
            r_s1_last    <= i_last_of_string;
            r_s1_fwd_hit <= tbl_wr.wr_en && (r_s1_slot == in_slot);
            r_s1_fwd_pos <= n_pos;
        end
    end

    // Per-string state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_win_begin <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_pos       <= '0;
                r_win_begin <= '0;
                r_best      <= '0;
                r_ovf       <= 1'b0;
            end else if (at_limit) begin
                r_ovf <= 1'b1;
            end else begin
                r_pos       <= n_pos;
                r_win_begin <= n_win_begin;
                r_best      <= n_best;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_done <= r_s1_last;
            if (at_limit) begin
                r_out_best <= ldrt_pkg::OUT_W'(r_best);
                r_out_win  <= '0;
                r_out_long <= 1'b1;
            end else begin
                r_out_best <= ldrt_pkg::OUT_W'(n_best);
                r_out_win  <= ldrt_pkg::OUT_W'(win);
                r_out_long <= r_ovf;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_best_length   = r_out_best;
    assign o_window_length = r_out_win;
    assign o_string_done   = r_out_done;
    assign o_too_long      = r_out_long;

endmodule
